// ===== rtl/core/burning_ship_escape_count_core_macros.svh =====
// Assertion helpers for the escape-count core
`ifndef BURNING_SHIP_ESCAPE_COUNT_CORE_MACROS_SVH
`define BURNING_SHIP_ESCAPE_COUNT_CORE_MACROS_SVH

`ifndef SYNTH
`define BSEC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bsec: implication check failed");
`define BSEC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bsec: next-cycle check failed");
`else
`define BSEC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BSEC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/core/bsec_pkg.sv =====
`timescale 1ns / 1ps
package bsec_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_FRAC_BITS = 28;

  localparam int CW     = 32;
  localparam int ZW     = 31;
  localparam int PIX_W  = 12;
  localparam int IMW_W  = 13;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 8;
  localparam int MUL_W  = CW + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = PIX_W + CW;
  localparam int DVS_W  = IMW_W;

  typedef enum logic [IDX_W-1:0] {
    REG_REAL_MIN  = 8'd0,
    REG_REAL_MAX  = 8'd1,
    REG_IMAG_MIN  = 8'd2,
    REG_IMAG_MAX  = 8'd3,
    REG_IMG_WIDTH = 8'd4,
    REG_MAX_ITER  = 8'd5
  } reg_idx_t;

  localparam logic signed [CW-1:0] RST_REAL_MIN = -32'sd671088640;
  localparam logic signed [CW-1:0] RST_REAL_MAX = 32'sd402653184;
  localparam logic signed [CW-1:0] RST_IMAG_MIN = -32'sd536870912;
  localparam logic signed [CW-1:0] RST_IMAG_MAX = 32'sd536870912;
  localparam logic [IMW_W-1:0]     RST_IMG_WIDTH = 13'd1024;
  localparam logic [CNT_W-1:0]     RST_MAX_ITER  = 16'd100;

  typedef struct packed {
    logic signed [CW-1:0] real_min;
    logic signed [CW-1:0] real_max;
    logic signed [CW-1:0] imag_min;
    logic signed [CW-1:0] imag_max;
    logic [IMW_W-1:0]     image_width;
    logic [CNT_W-1:0]     max_iterations;
  } cfg_regs_t;

endpackage

// ===== rtl/core/bsec_cfg.sv =====
`timescale 1ns / 1ps
module bsec_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsec_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bsec_pkg::CW-1:0]         cfg_data,
  output bsec_pkg::cfg_regs_t             regs
);

  bsec_pkg::cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.real_min       <= bsec_pkg::RST_REAL_MIN;
      regs_r.real_max       <= bsec_pkg::RST_REAL_MAX;
      regs_r.imag_min       <= bsec_pkg::RST_IMAG_MIN;
      regs_r.imag_max       <= bsec_pkg::RST_IMAG_MAX;
      regs_r.image_width    <= bsec_pkg::RST_IMG_WIDTH;
      regs_r.max_iterations <= bsec_pkg::RST_MAX_ITER;
    end else if (cfg_valid) begin
      case (cfg_index)
        bsec_pkg::REG_REAL_MIN:  regs_r.real_min <= $signed(cfg_data);
        bsec_pkg::REG_REAL_MAX:  regs_r.real_max <= $signed(cfg_data);
        bsec_pkg::REG_IMAG_MIN:  regs_r.imag_min <= $signed(cfg_data);
        bsec_pkg::REG_IMAG_MAX:  regs_r.imag_max <= $signed(cfg_data);
        bsec_pkg::REG_IMG_WIDTH: regs_r.image_width <= cfg_data[bsec_pkg::IMW_W-1:0];
        bsec_pkg::REG_MAX_ITER:  regs_r.max_iterations <= cfg_data[bsec_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/bsec_mul.sv =====
`timescale 1ns / 1ps
module bsec_mul (
  input  logic                                  clk,
  input  logic signed [bsec_pkg::MUL_W-1:0]     op_a,
  input  logic signed [bsec_pkg::MUL_W-1:0]     op_b,
  output logic signed [bsec_pkg::PROD_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== rtl/core/bsec_div.sv =====
`timescale 1ns / 1ps
module bsec_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bsec_pkg::DVD_W-1:0]    dividend,
  input  logic [bsec_pkg::DVS_W-1:0]    divisor,
  output logic [bsec_pkg::DVD_W-1:0]    quot,
  output logic                          done
);

  localparam int DVD_W = bsec_pkg::DVD_W;
  localparam int DVS_W = bsec_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign quot   = dvd_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/burning_ship_escape_count_core.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_pixel_col, in_pixel_row
// out      output     out_valid / out_ready  out_col, out_row, out_iter_count, out_escaped
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item runs two axes of one multiply and a restoring divide each, then passes of the
// shared 33x33 multiplier for zr*zr, zi*zi and zr*zi per iteration, then hands the result to
// the output register once it is free.
// One item is in flight at a time; a new word is taken while the last result waits.
// Reset (rst_n, synchronous) loads the default view and idles the sequencer.
`timescale 1ns / 1ps
`include "burning_ship_escape_count_core_macros.svh"
module burning_ship_escape_count_core #(
  parameter int MAX_WIDTH = bsec_pkg::DEF_MAX_WIDTH,
  parameter int FRAC_BITS = bsec_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsec_pkg::PIX_W-1:0]    in_pixel_col,
  input  logic [bsec_pkg::PIX_W-1:0]    in_pixel_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bsec_pkg::PIX_W-1:0]    out_col,
  output logic [bsec_pkg::PIX_W-1:0]    out_row,
  output logic [bsec_pkg::CNT_W-1:0]    out_iter_count,
  output logic                          out_escaped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsec_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bsec_pkg::CW-1:0]       cfg_data
);

  localparam int CW     = bsec_pkg::CW;
  localparam int ZW     = bsec_pkg::ZW;
  localparam int PIX_W  = bsec_pkg::PIX_W;
  localparam int CNT_W  = bsec_pkg::CNT_W;
  localparam int MUL_W  = bsec_pkg::MUL_W;
  localparam int PROD_W = bsec_pkg::PROD_W;
  localparam int DVD_W  = bsec_pkg::DVD_W;
  localparam int DVS_W  = bsec_pkg::DVS_W;
  localparam int T_W    = DVD_W + 1;
  localparam int CS_W   = T_W + 1;
  localparam int SQ_W   = 2 * ZW;
  localparam int EXT_W  = SQ_W + 2;
  localparam int ESC_SH = 2 * FRAC_BITS + 2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAPM = 8'b0000_0010,
    S_DIVS = 8'b0000_0100,
    S_DIVW = 8'b0000_1000,
    S_RR   = 8'b0001_0000,
    S_II   = 8'b0010_0000,
    S_RI   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  bsec_pkg::cfg_regs_t cfg;

  state_t               state_r, state_nxt;
  logic [PIX_W-1:0]     col_r, row_r;
  logic                 axis_r;
  logic                 neg_r;
  logic [DVS_W-1:0]     w_r, w_eff;
  logic signed [CW-1:0] cr_r, ci_r;
  logic [ZW-1:0]        zr_r, zi_r;
  logic [SQ_W-1:0]      rr_r;
  logic [CNT_W-1:0]     count_r, count_inc;
  logic                 upd_zi_r;
  logic                 esc_r;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_col_r, out_row_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_esc_r;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MUL_W-1:0]  span;

  logic signed [T_W-1:0]  t_val;
  logic [T_W-1:0]         t_mag;
  logic                   div_start;
  logic [DVD_W-1:0]       div_quot;
  logic                   div_done;
  logic signed [T_W-1:0]  q_s;
  logic signed [CS_W-1:0] coord_sum;
  logic signed [CW-1:0]   coord_sat;
  logic signed [CW-1:0]   lo_sel;

  logic [SQ_W-1:0]         ii_val;
  logic [SQ_W:0]           mag_sum;
  logic                    esc_hit;
  logic signed [EXT_W-1:0] diff, diff_sh, nr_full, nr_abs;
  logic signed [EXT_W-1:0] ri_sh, ni_full, ni_abs;
  logic [ZW-1:0]           nr_sat, ni_sat;
  logic                    out_free;

  bsec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  bsec_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  bsec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (t_mag[DVD_W-1:0]),
    .divisor  (w_r),
    .quot     (div_quot),
    .done     (div_done)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_iter_count = out_cnt_r;
  assign out_escaped    = out_esc_r;
  assign out_free       = !out_valid_r || out_ready;
  assign div_start      = (state_r == S_DIVS);
  assign count_inc      = count_r + 1'b1;

  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = DVS_W'(1);
    end else if (int'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = DVS_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    if (axis_r) begin
      span   = MUL_W'(cfg.imag_max) - MUL_W'(cfg.imag_min);
      lo_sel = cfg.imag_min;
    end else begin
      span   = MUL_W'(cfg.real_max) - MUL_W'(cfg.real_min);
      lo_sel = cfg.real_min;
    end
    case (state_r)
      S_MAPM: begin
        op_a = $signed(MUL_W'(axis_r ? row_r : col_r));
        op_b = span;
      end
      S_RR: begin
        op_a = $signed(MUL_W'(zr_r));
        op_b = $signed(MUL_W'(zr_r));
      end
      S_II: begin
        op_a = $signed(MUL_W'(zi_r));
        op_b = $signed(MUL_W'(zi_r));
      end
      S_RI: begin
        op_a = $signed(MUL_W'(zr_r));
        op_b = $signed(MUL_W'(zi_r));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // coordinate mapping: sign/magnitude around the divider, then saturate
  always_comb begin
    t_val     = prod_r[T_W-1:0];
    t_mag     = t_val[T_W-1] ? T_W'(-t_val) : T_W'(t_val);
    q_s       = neg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    coord_sum = CS_W'(lo_sel) + CS_W'(q_s);
    if (coord_sum > CS_W'(32'sh7fff_ffff)) begin
      coord_sat = 32'sh7fff_ffff;
    end else if (coord_sum < -CS_W'(33'sh0_8000_0000)) begin
      coord_sat = -32'sh7fff_ffff - 32'sd1;
    end else begin
      coord_sat = coord_sum[CW-1:0];
    end
  end

  // iteration datapath
  always_comb begin
    ii_val  = prod_r[SQ_W-1:0];
    mag_sum = {1'b0, rr_r} + {1'b0, ii_val};
    esc_hit = (mag_sum >> ESC_SH) != '0;
    diff    = $signed({2'b00, rr_r}) - $signed({2'b00, ii_val});
    diff_sh = diff >>> FRAC_BITS;
    nr_full = diff_sh + EXT_W'(cr_r);
    nr_abs  = nr_full[EXT_W-1] ? -nr_full : nr_full;
    nr_sat  = (|nr_abs[EXT_W-1:ZW]) ? '1 : nr_abs[ZW-1:0];
    ri_sh   = $signed({2'b00, prod_r[SQ_W-1:0]} >> (FRAC_BITS - 1));
    ni_full = ri_sh + EXT_W'(ci_r);
    ni_abs  = ni_full[EXT_W-1] ? -ni_full : ni_full;
    ni_sat  = (|ni_abs[EXT_W-1:ZW]) ? '1 : ni_abs[ZW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MAPM;
      S_MAPM: state_nxt = S_DIVS;
      S_DIVS: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          if (!axis_r) begin
            state_nxt = S_MAPM;
          end else if (cfg.max_iterations == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RR;
          end
        end
      end
      S_RR:   state_nxt = S_II;
      S_II:   state_nxt = S_RI;
      S_RI: begin
        if (esc_hit || count_inc == cfg.max_iterations) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RR;
        end
      end
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      upd_zi_r    <= 1'b0;
      axis_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          axis_r   <= 1'b0;
          upd_zi_r <= 1'b0;
        end
        S_DIVW:  if (div_done) axis_r <= 1'b1;
        S_RI:    upd_zi_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        col_r <= in_pixel_col;
        row_r <= in_pixel_row;
        w_r   <= w_eff;
      end
      S_DIVS: neg_r <= t_val[T_W-1];
      S_DIVW: begin
        if (div_done) begin
          if (axis_r) begin
            ci_r <= coord_sat;
          end else begin
            cr_r <= coord_sat;
          end
          zr_r    <= '0;
          zi_r    <= '0;
          count_r <= '0;
          esc_r   <= 1'b0;
        end
      end
      S_RR:   if (upd_zi_r) zi_r <= ni_sat;
      S_II:   rr_r <= prod_r[SQ_W-1:0];
      S_RI: begin
        if (esc_hit) begin
          esc_r <= 1'b1;
        end else begin
          zr_r    <= nr_sat;
          count_r <= count_inc;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_col_r <= col_r;
          out_row_r <= row_r;
          out_cnt_r <= count_r;
          out_esc_r <= esc_r;
        end
      end
      default: begin
      end
    endcase
  end

  `BSEC_ASSERT_IMP(a_iter_below_limit, clk, rst_n, state_r == S_RI, count_r < cfg.max_iterations)
  `BSEC_ASSERT_IMP(a_escape_before_limit, clk, rst_n, out_valid_r && out_esc_r, out_cnt_r < cfg.max_iterations)
  `BSEC_ASSERT_IMP(a_div_done_in_wait, clk, rst_n, div_done, state_r == S_DIVW)
  `BSEC_ASSERT_IMP(a_first_pass_from_origin, clk, rst_n, state_r == S_RR && !upd_zi_r, zr_r == '0 && zi_r == '0)
  `BSEC_ASSERT_NXT(a_fin_loads_output, clk, rst_n, state_r == S_FIN && out_free, out_valid_r && state_r == S_IDLE)

endmodule
